/* hdl/bps_pkg.sv */
package bps_pkg;

    localparam int NUM_UNITS_DEF = 64;

    localparam int OP_W    = 2;
    localparam int LEN_W   = 22;
    localparam int SLOT_FW = 6;
    localparam int UNIT_W  = 17;
    localparam int COUNT_W = 7;
    localparam int TOTAL_W = 32;
    localparam int CAP_W   = UNIT_W + COUNT_W;
    localparam int ST_W    = 2;
    localparam int IDX_W   = 2;

    localparam logic [OP_W-1:0] OP_PUT      = 2'd0;
    localparam logic [OP_W-1:0] OP_GET      = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE  = 2'd2;
    localparam logic [OP_W-1:0] OP_FEEDBACK = 2'd3;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_REJECT   = 2'd1;
    localparam logic [ST_W-1:0] ST_MISMATCH = 2'd2;

    localparam logic [IDX_W-1:0] CFG_UNIT_SIZE  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_UNIT_COUNT = 2'd1;
    localparam logic [IDX_W-1:0] CFG_THRESHOLD  = 2'd2;

    localparam logic [UNIT_W-1:0]  UNIT_SIZE_RST  = UNIT_W'(4096);
    localparam logic [UNIT_W-1:0]  UNIT_SIZE_MAX  = UNIT_W'(65536);
    localparam logic [COUNT_W-1:0] UNIT_COUNT_RST = COUNT_W'(64);
    localparam logic [TOTAL_W-1:0] THRESHOLD_RST  = TOTAL_W'((256 * 1024) / 2);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_PUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic cfg_we;
        logic emit_single;
        logic emit_slot;
    } t_dp_cmd;

    typedef struct packed {
        logic put_go;
        logic put_last;
        logic out_free;
    } t_dp_sts;

    function automatic logic [UNIT_W-1:0] unit_eff(input logic [UNIT_W-1:0] raw);
        logic [UNIT_W-1:0] v;
        v = raw;
        if (raw == '0) begin
            v = UNIT_W'(1);
        end else if (raw > UNIT_SIZE_MAX) begin
            v = UNIT_SIZE_MAX;
        end
        return v;
    endfunction

endpackage

/* hdl/bps_in_if.sv */
interface bps_in_if;
    logic                         valid;
    logic                         ready;
    logic [bps_pkg::OP_W-1:0]    operation;
    logic [bps_pkg::LEN_W-1:0]   data_length;
    logic [bps_pkg::SLOT_FW-1:0] release_slot;

    modport source (output valid, output operation, output data_length,
                    output release_slot, input ready);
    modport sink (input valid, input operation, input data_length,
                  input release_slot, output ready);
endinterface

/* hdl/bps_out_if.sv */
interface bps_out_if;
    logic                         valid;
    logic                         ready;
    logic [bps_pkg::ST_W-1:0]    status;
    logic [bps_pkg::SLOT_FW-1:0] slot;
    logic [bps_pkg::UNIT_W-1:0]  block_length;
    logic                         last;
    logic [bps_pkg::TOTAL_W-1:0] fed_bytes;

    modport source (output valid, output status, output slot, output block_length,
                    output last, output fed_bytes, input ready);
    modport sink (input valid, input status, input slot, input block_length,
                  input last, input fed_bytes, output ready);
endinterface

/* hdl/bps_cfg_if.sv */
interface bps_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [bps_pkg::IDX_W-1:0]   index;
    logic [bps_pkg::TOTAL_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* hdl/bps_ctrl.sv */
module bps_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  bps_pkg::t_dp_sts i_sts,
    output bps_pkg::t_dp_cmd o_cmd
);
    import bps_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !i_cfg_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.put_go) begin
                    n_state = S_PUT;
                end else if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_PUT: begin
                if (i_sts.out_free && i_sts.put_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_cfg_ready = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                o_cfg_ready    = 1'b1;
                o_in_ready     = !i_cfg_valid;
                o_cmd.cfg_we   = i_cfg_valid;
                o_cmd.capture  = i_in_valid && !i_cfg_valid;
            end
            S_EVAL: begin
                o_cmd.emit_single = i_sts.out_free && !i_sts.put_go;
            end
            S_PUT: begin
                o_cmd.emit_slot = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

/* hdl/bps_datapath.sv */
module bps_datapath #(
    parameter int NUM_UNITS = bps_pkg::NUM_UNITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bps_pkg::t_dp_cmd              i_cmd,
    output bps_pkg::t_dp_sts              o_sts,
    input  logic [bps_pkg::OP_W-1:0]      i_operation,
    input  logic [bps_pkg::LEN_W-1:0]     i_data_length,
    input  logic [bps_pkg::SLOT_FW-1:0]   i_release_slot,
    input  logic [bps_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [bps_pkg::TOTAL_W-1:0]   i_cfg_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [bps_pkg::ST_W-1:0]      o_status,
    output logic [bps_pkg::SLOT_FW-1:0]   o_slot,
    output logic [bps_pkg::UNIT_W-1:0]    o_block_length,
    output logic                          o_last,
    output logic [bps_pkg::TOTAL_W-1:0]   o_fed_bytes
);
    import bps_pkg::*;

    localparam int SLOT_W = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;

    function automatic logic [COUNT_W-1:0] count_eff(input logic [COUNT_W-1:0] raw);
        logic [COUNT_W-1:0] v;
        v = raw;
        if (raw == '0) begin
            v = COUNT_W'(1);
        end else if (raw > COUNT_W'(NUM_UNITS)) begin
            v = COUNT_W'(NUM_UNITS);
        end
        return v;
    endfunction

    function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] p,
                                                    input logic [COUNT_W-1:0] c);
        logic [COUNT_W-1:0] n;
        n = COUNT_W'(p) + COUNT_W'(1);
        return (n >= c) ? '0 : (p + SLOT_W'(1));
    endfunction

    logic [UNIT_W-1:0]  r_unit;
    logic [COUNT_W-1:0] r_count_eff;
    logic [TOTAL_W-1:0] r_threshold;

    logic [SLOT_W-1:0]  r_empty_head;
    logic [SLOT_W-1:0]  r_filled_head;
    logic [SLOT_W-1:0]  r_release_head;
    logic [COUNT_W-1:0] r_empty_count;
    logic [COUNT_W-1:0] r_filled_count;
    logic [COUNT_W-1:0] r_release_count;
    logic [TOTAL_W-1:0] r_received;
    logic [TOTAL_W-1:0] r_reported;

    logic [OP_W-1:0]    r_op;
    logic [LEN_W-1:0]   r_len;
    logic [LEN_W-1:0]   r_rem;
    logic [SLOT_FW-1:0] r_rel;
    logic [CAP_W-1:0]   r_cap;

    logic [UNIT_W-1:0]  r_mem [NUM_UNITS];
    logic [UNIT_W-1:0]  r_rd_data;

    logic               r_out_valid;
    logic [ST_W-1:0]    r_status;
    logic [SLOT_FW-1:0] r_slot;
    logic [UNIT_W-1:0]  r_blen;
    logic               r_last;
    logic [TOTAL_W-1:0] r_fed;

    logic [ST_W-1:0]    n_status;
    logic [SLOT_FW-1:0] n_slot;
    logic [UNIT_W-1:0]  n_blen;
    logic               n_last;
    logic [TOTAL_W-1:0] n_fed;
    logic [COUNT_W-1:0] n_count_eff;

    logic [UNIT_W-1:0]  w_part;
    logic               w_admit;
    logic               w_fb_due;
    logic               w_cfg_hit;
    logic               w_emit;

    assign w_part   = (r_rem > LEN_W'(r_unit)) ? r_unit : r_rem[UNIT_W-1:0];
    assign w_admit  = CAP_W'(r_len) < r_cap;
    assign w_fb_due = (r_received - r_reported) > r_threshold;
    assign w_emit   = i_cmd.emit_single || i_cmd.emit_slot;

    assign w_cfg_hit = (i_cfg_index == CFG_UNIT_SIZE) || (i_cfg_index == CFG_UNIT_COUNT)
                    || (i_cfg_index == CFG_THRESHOLD);
    assign n_count_eff = (i_cfg_index == CFG_UNIT_COUNT) ? count_eff(i_cfg_data[COUNT_W-1:0])
                                                        : r_count_eff;

    assign o_sts.put_go   = (r_op == OP_PUT) && (r_len != '0) && w_admit;
    assign o_sts.put_last = r_rem <= LEN_W'(r_unit);
    assign o_sts.out_free = !r_out_valid || i_ready;

    always_comb begin
        n_status = ST_OK;
        n_slot   = '0;
        n_blen   = '0;
        n_last   = 1'b1;
        n_fed    = '0;
        if (i_cmd.emit_slot) begin
            n_slot = SLOT_FW'(r_empty_head);
            n_blen = w_part;
            n_last = o_sts.put_last;
        end else begin
            case (r_op)
                OP_PUT: begin
                    if (r_len != '0) begin
                        n_status = ST_REJECT;
                    end
                end
                OP_GET: begin
                    if (r_filled_count == '0) begin
                        n_status = ST_REJECT;
                    end else begin
                        n_slot = SLOT_FW'(r_filled_head);
                        n_blen = r_rd_data;
                    end
                end
                OP_RELEASE: begin
                    if (r_release_count == '0) begin
                        n_status = ST_MISMATCH;
                    end else begin
                        n_slot = SLOT_FW'(r_release_head);
                        if (SLOT_FW'(r_release_head) != r_rel) begin
                            n_status = ST_MISMATCH;
                        end
                    end
                end
                OP_FEEDBACK: begin
                    if (w_fb_due) begin
                        n_fed = r_received;
                    end else begin
                        n_status = ST_REJECT;
                    end
                end
                default: n_status = ST_REJECT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit          <= UNIT_SIZE_RST;
            r_count_eff     <= count_eff(UNIT_COUNT_RST);
            r_threshold     <= THRESHOLD_RST;
            r_empty_head    <= '0;
            r_filled_head   <= '0;
            r_release_head  <= '0;
            r_empty_count   <= count_eff(UNIT_COUNT_RST);
            r_filled_count  <= '0;
            r_release_count <= '0;
            r_received      <= '0;
            r_reported      <= '0;
        end else if (i_cmd.cfg_we) begin
            case (i_cfg_index)
                CFG_UNIT_SIZE:  r_unit      <= unit_eff(i_cfg_data[UNIT_W-1:0]);
                CFG_UNIT_COUNT: r_count_eff <= n_count_eff;
                CFG_THRESHOLD:  r_threshold <= i_cfg_data;
                default: ;
            endcase
            if (w_cfg_hit) begin
                r_empty_head    <= '0;
                r_filled_head   <= '0;
                r_release_head  <= '0;
                r_empty_count   <= n_count_eff;
                r_filled_count  <= '0;
                r_release_count <= '0;
                r_received      <= '0;
                r_reported      <= '0;
            end
        end else if (i_cmd.emit_slot) begin
            r_empty_head   <= ring_next(r_empty_head, r_count_eff);
            r_empty_count  <= r_empty_count - COUNT_W'(1);
            r_filled_count <= r_filled_count + COUNT_W'(1);
            if (o_sts.put_last) begin
                r_received <= r_received + TOTAL_W'(r_len);
            end
        end else if (i_cmd.emit_single) begin
            case (r_op)
                OP_GET: begin
                    if (r_filled_count != '0) begin
                        r_filled_head   <= ring_next(r_filled_head, r_count_eff);
                        r_filled_count  <= r_filled_count - COUNT_W'(1);
                        r_release_count <= r_release_count + COUNT_W'(1);
                    end
                end
                OP_RELEASE: begin
                    if (r_release_count != '0) begin
                        r_release_head  <= ring_next(r_release_head, r_count_eff);
                        r_release_count <= r_release_count - COUNT_W'(1);
                        r_empty_count   <= r_empty_count + COUNT_W'(1);
                    end
                end
                OP_FEEDBACK: begin
                    if (w_fb_due) begin
                        r_reported <= r_received;
                    end
                end
                default: ;
            endcase
        end
    end

    // capture the beat and size the pool against it
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_operation;
            r_len <= i_data_length;
            r_rem <= i_data_length;
            r_rel <= i_release_slot;
            r_cap <= CAP_W'(r_empty_count) * CAP_W'(r_unit);
        end else if (i_cmd.emit_slot) begin
            r_rem <= r_rem - LEN_W'(w_part);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_slot) begin
            r_mem[r_empty_head] <= w_part;
        end
        r_rd_data <= r_mem[r_filled_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_status <= n_status;
            r_slot   <= n_slot;
            r_blen   <= n_blen;
            r_last   <= n_last;
            r_fed    <= n_fed;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_slot         = r_slot;
    assign o_block_length = r_blen;
    assign o_last         = r_last;
    assign o_fed_bytes    = r_fed;

    a_count_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (COUNT_W + 1)'(r_empty_count) + (COUNT_W + 1)'(r_filled_count)
            + (COUNT_W + 1)'(r_release_count) == (COUNT_W + 1)'(r_count_eff))
        else $error("block counts do not add up to the pool size");

    a_slot_has_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_slot |-> r_empty_count != '0)
        else $error("put slot emitted with no empty block");

    a_put_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_slot && o_sts.put_last |=> r_rem == '0)
        else $error("last put slot left bytes behind");

    a_single_not_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_single |-> !o_sts.put_go)
        else $error("single result issued for an admitted put");

endmodule

/* hdl/block_pool_stream_buffer.sv */
// Channel   Dir  Payload                                           Handshake
// i_in      in   operation, data_length, release_slot              valid/ready
// i_cfg     in   index, data                                       valid/ready
// o_out     out  status, slot, block_length, last, fed_bytes       valid/ready
//
// An item is taken in an idle cycle and evaluated the next cycle: get, release,
// feedback and refused or empty puts give one beat each, an admitted put of n blocks
// gives n slot beats, one per cycle barring stalls. The admission check waits on the
// registered empty_count * unit_size product; get waits on the slot-length RAM read.
// Reset is synchronous; it restores the default registers and the initial lists.
// A stalled output holds its beat in the output register and freezes the put.
// A configuration beat wins over an input beat offered in the same idle cycle.
module block_pool_stream_buffer #(
    parameter int NUM_UNITS = bps_pkg::NUM_UNITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bps_in_if.sink    i_in,
    bps_cfg_if.sink   i_cfg,
    bps_out_if.source o_out
);
    import bps_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    bps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_cfg_valid (i_cfg.valid),
        .o_cfg_ready (i_cfg.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    bps_datapath #(
        .NUM_UNITS (NUM_UNITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_operation    (i_in.operation),
        .i_data_length  (i_in.data_length),
        .i_release_slot (i_in.release_slot),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .o_valid        (o_out.valid),
        .i_ready        (o_out.ready),
        .o_status       (o_out.status),
        .o_slot         (o_out.slot),
        .o_block_length (o_out.block_length),
        .o_last         (o_out.last),
        .o_fed_bytes    (o_out.fed_bytes)
    );

endmodule
